>>> sv/bdc_pkg.sv
// Shared types and constants for the button debounce and click classifier.
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 2;
    localparam int TALLY_W = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] CLICK_GAP_RESET  = 16'd300;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } ev_t;

    typedef enum logic [INDEX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_CLICK_GAP  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] click_gap_ms;
    } cfg_t;

    typedef struct packed {
        ev_t  event_code;
        logic pressed_now;
    } result_t;

endpackage

`default_nettype wire

>>> sv/bdc_cfg.sv
// Configuration register file: three 16-bit timing registers.
`timescale 1ns / 1ps
`default_nettype none

module bdc_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [bdc_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [bdc_pkg::CFG_W-1:0]   cfg_data,
    output bdc_pkg::cfg_t                   cfg
);
    import bdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE:   cfg_next.debounce_ms   = cfg_data;
                CFG_LONG_PRESS: cfg_next.long_press_ms = cfg_data;
                CFG_CLICK_GAP:  cfg_next.click_gap_ms  = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RESET;
            cfg_reg.long_press_ms <= LONG_PRESS_RESET;
            cfg_reg.click_gap_ms  <= CLICK_GAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> sv/bdc_core.sv
// Debounce state and click classification, one sample per cycle while advance is set.
`timescale 1ns / 1ps
`default_nettype none

module bdc_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic                       level,
    input  wire logic [bdc_pkg::TIME_W-1:0] now_ms,
    input  wire bdc_pkg::cfg_t              cfg,
    output bdc_pkg::result_t                result
);
    import bdc_pkg::*;

    logic               pressed_reg, pressed_next;
    logic [TIME_W-1:0]  press_time_reg, press_time_next;
    logic [TIME_W-1:0]  release_time_reg, release_time_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [TIME_W-1:0]  since_release;
    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  idle;
    ev_t                ev;

    always_comb
    begin
        pressed_next      = pressed_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        tally_next        = tally_reg;
        ev                = EV_NONE;
        since_release     = now_ms - release_time_reg;
        held              = now_ms - press_time_reg;

        if (level && !pressed_reg)
        begin
            if (since_release > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms})
            begin
                pressed_next    = 1'b1;
                press_time_next = now_ms;
            end
        end
        else if (!level && pressed_reg)
        begin
            if (held > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms})
            begin
                pressed_next      = 1'b0;
                release_time_next = now_ms;
                if (held >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms})
                begin
                    ev         = EV_LONG;
                    tally_next = '0;
                end
                else if (tally_reg < TALLY_MAX)
                begin
                    tally_next = tally_reg + 1'b1;
                end
            end
        end

        // report the tally once the idle gap after release has run out
        idle = now_ms - release_time_next;
        if (!pressed_next && (tally_next != '0) &&
            (idle > {{(TIME_W-CFG_W){1'b0}}, cfg.click_gap_ms}))
        begin
            ev         = (tally_next == 2'd1) ? EV_SINGLE : EV_DOUBLE;
            tally_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg      <= 1'b0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            tally_reg        <= '0;
        end
        else if (advance)
        begin
            pressed_reg      <= pressed_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            tally_reg        <= tally_next;
        end
    end

    assign result.event_code  = ev;
    assign result.pressed_now = pressed_next;

endmodule

`default_nettype wire

>>> sv/button_debounce_click_classifier_unit.sv
// Top level of the button debounce and click classifier.
`timescale 1ns / 1ps
`default_nettype none

// Each request on the slave stream is one sample of the button pin with its
// millisecond timestamp; each sample yields exactly one result on the master
// stream carrying the event (none, single, double, long press) and the
// debounced level. A sample waits in the input register until the output
// slot is free or being drained, then its result is loaded into the output
// register. While the master side keeps taking results, one sample is
// accepted every cycle; a stalled result lets exactly one more sample into
// the input register and then holds the input off until the result is
// taken. The rate is set by the single state update between the two
// registers: debounce compare, tally step and gap compare in one pass.
// Timing registers are written through the cfg port by the user only while
// the stream is idle; the block itself does not enforce this.

module button_debounce_click_classifier_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // slave stream: [0] raw_level, [32:1] now_ms, [39:33] zero
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bdc_pkg::IN_TDATA_W-1:0]  s_tdata,
    // master stream: [1:0] event_code, [2] pressed_now, [7:3] zero
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [bdc_pkg::OUT_TDATA_W-1:0] m_tdata,
    // register write port
    input  wire logic                            cfg_we,
    input  wire logic [bdc_pkg::INDEX_W-1:0]     cfg_index,
    input  wire logic [bdc_pkg::CFG_W-1:0]       cfg_data
);
    import bdc_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_result_reg;
    logic              s_accept;
    logic              advance;
    cfg_t              cfg;
    result_t           result;

    // move the held sample on whenever the output slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the sample payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[TIME_W:1];
        end
    end

    // hold the result until the master side takes it
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    bdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .level   (in_level_reg),
        .now_ms  (in_now_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-3){1'b0}}, out_result_reg.pressed_now,
                       out_result_reg.event_code};

endmodule

`default_nettype wire

>>> sv/bdc_checker.sv
// Port-level checks for the click classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bdc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [bdc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bdc_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input only stalls when a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with output free");

    // click reports only come while released
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == EV_SINGLE || m_tdata[1:0] == EV_DOUBLE)
        |-> !m_tdata[2])
        else $error("click reported while pressed");

    // long press is reported on the accepted release
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == EV_LONG |-> !m_tdata[2])
        else $error("long press reported while pressed");

endmodule

bind button_debounce_click_classifier_unit bdc_checker u_bdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/tb_button_debounce_click_classifier_unit.sv
// Self-checking testbench for the button debounce and click classifier unit.
`timescale 1ns / 1ps

module tb_button_debounce_click_classifier_unit;

    import bdc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SHOWN_MAX   = 10;

    logic clk;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [INDEX_W-1:0]     cfg_index = CFG_DEBOUNCE;
    logic [CFG_W-1:0]       cfg_data = '0;

    button_debounce_click_classifier_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [0] raw_level, [32:1] now_ms, [39:33] zero
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [1:0] event_code, [2] pressed_now, [7:3] zero
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Samples waiting to be sent, and the results they must produce, oldest first.
    logic [IN_TDATA_W-1:0] sample_q[$];
    result_t               expected_events[$];

    // Handshake seen at the last rising edge; the driver reads it at the following falling edge.
    logic in_fire = 1'b0;
    // Suppress all idling on both sides while set.
    logic quiet = 1'b0;

    int send_wait  = 0;
    int stall_wait = 0;
    int cycle_cnt  = 0;
    int bad_results = 0;
    int results_seen = 0;
    int n_samples = 0;

    // Predictor copy of the timing registers and the classifier state.
    logic [CFG_W-1:0]   debounce_q;
    logic [CFG_W-1:0]   long_press_q;
    logic [CFG_W-1:0]   click_gap_q;
    logic               btn_down;
    logic [TIME_W-1:0]  t_press;
    logic [TIME_W-1:0]  t_release;
    logic [TALLY_W-1:0] tally;

    // Stimulus side: the time cursor and the register values last programmed.
    logic [TIME_W-1:0] t_now = '0;
    int unsigned       set_dbn = DEBOUNCE_RESET;
    int unsigned       set_lp  = LONG_PRESS_RESET;
    int unsigned       set_gap = CLICK_GAP_RESET;

    result_t want;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Advance the debounced state by one sample and return the result it yields.
    function automatic result_t classify_sample(input logic level,
                                                input logic [TIME_W-1:0] now);
        result_t           res;
        logic [TIME_W-1:0] held;
        res.event_code = EV_NONE;
        if (level && !btn_down)
        begin
            // accept the press only once the release has settled
            if (now - t_release > debounce_q)
            begin
                btn_down = 1'b1;
                t_press  = now;
            end
        end
        else if (!level && btn_down)
        begin
            held = now - t_press;
            if (held > debounce_q)
            begin
                btn_down  = 1'b0;
                t_release = now;
                // a long press reports on release and drops any pending clicks
                if (held >= long_press_q)
                begin
                    res.event_code = EV_LONG;
                    tally = '0;
                end
                else if (tally < TALLY_MAX)
                begin
                    tally = tally + 1'b1;
                end
            end
        end
        // report the clicks once the button has been idle long enough
        if (!btn_down && tally != 0 && (now - t_release) > click_gap_q)
        begin
            res.event_code = (tally == 1) ? EV_SINGLE : EV_DOUBLE;
            tally = '0;
        end
        res.pressed_now = btn_down;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A delay near a threshold: just under, on, just over, or somewhere around it.
    function automatic int unsigned near_value(input int unsigned x);
        case ($urandom_range(0, 6))
            0: return (x > 0) ? x - 1 : 0;
            1: return x;
            2: return x + 1;
            3: return $urandom_range(0, x);
            4: return x + $urandom_range(0, x + 1);
            5: return $urandom_range(0, 3);
            default: return x + $urandom_range(2, 40);
        endcase
    endfunction

    task automatic push_at(input logic level, input logic [TIME_W-1:0] t);
        t_now = t;
        sample_q.push_back({7'd0, t, level});
        n_samples++;
    endtask

    task automatic push_sample(input logic level, input logic [TIME_W-1:0] dt);
        push_at(level, t_now + dt);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing(input int unsigned dbn, input int unsigned lp,
                                  input int unsigned gap);
        set_dbn = dbn;
        set_lp  = lp;
        set_gap = gap;
        write_reg(CFG_DEBOUNCE, CFG_W'(dbn));
        write_reg(CFG_LONG_PRESS, CFG_W'(lp));
        write_reg(CFG_CLICK_GAP, CFG_W'(gap));
        end_writes();
    endtask

    // Hold until every sample is sent and every result is back, then let the pipe drain.
    task automatic settle();
        do
            @(posedge clk);
        while (sample_q.size() != 0 || s_tvalid || expected_events.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Mostly whole presses with contact bounce and timings near the thresholds,
    // the rest random samples and timestamps that jump backwards.
    task automatic random_phase(input int count);
        int          stop_at;
        int          roll;
        int unsigned hold;
        stop_at = n_samples + count;
        while (n_samples < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
            begin
                repeat ($urandom_range(0, 3))
                    push_sample(1'($urandom_range(0, 1)), $urandom_range(0, 3));
                push_sample(1'b1, near_value(set_dbn));
                if ($urandom_range(0, 1))
                    push_sample(1'b1, $urandom_range(0, set_dbn));
                hold = $urandom_range(0, 1) ? set_dbn : set_lp;
                push_sample(1'b0, near_value(hold));
                repeat ($urandom_range(0, 2))
                    push_sample($urandom_range(0, 9) == 0, near_value(set_gap));
            end
            else if (roll < 92)
            begin
                push_at(1'($urandom_range(0, 1)), $urandom());
            end
            else
            begin
                push_sample(1'($urandom_range(0, 1)),
                            32'hFFFF_FFFF - $urandom_range(0, 2 * set_gap + 50));
            end
        end
    endtask

    // Driver: change inputs on the falling edge only.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            // a request still waiting for tready keeps its data
            if (!s_tvalid || in_fire)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    s_tvalid  <= 1'b1;
                    s_tdata   <= sample_q.pop_front();
                    send_wait = idle_len();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            if (stall_wait > 0)
            begin
                stall_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 20)
                    stall_wait = idle_len();
            end
        end
    end

    // Monitor: sample both handshakes and the register port on the rising edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire      = 1'b0;
            debounce_q   = DEBOUNCE_RESET;
            long_press_q = LONG_PRESS_RESET;
            click_gap_q  = CLICK_GAP_RESET;
            btn_down     = 1'b0;
            t_press      = '0;
            t_release    = '0;
            tally        = '0;
        end
        else
        begin
            // check the outgoing result before queueing the new request's result
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_events.size() == 0)
                begin
                    bad_results++;
                    if (bad_results <= SHOWN_MAX)
                        $display("result %0d with none pending: tdata %0h",
                                 results_seen, m_tdata);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tdata[1:0] !== want.event_code || m_tdata[2] !== want.pressed_now
                        || m_tdata[7:3] !== 5'd0)
                    begin
                        bad_results++;
                        if (bad_results <= SHOWN_MAX)
                            $display({"result %0d: event exp %0d got %0d, ",
                                      "pressed exp %0b got %0b, pad got %0h"},
                                     results_seen, want.event_code, m_tdata[1:0],
                                     want.pressed_now, m_tdata[2], m_tdata[7:3]);
                    end
                end
            end
            in_fire = s_tvalid && s_tready;
            if (in_fire)
                expected_events.push_back(classify_sample(s_tdata[0], s_tdata[32:1]));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE:   debounce_q   = cfg_data;
                    CFG_LONG_PRESS: long_press_q = cfg_data;
                    CFG_CLICK_GAP:  click_gap_q  = cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing (20 / 1000 / 300): debounce and gap bounds are exclusive,
        // tally saturation, long press reported only on release, long press
        // clearing a pending click, wrap and backward-jumping timestamps.
        push_at(1'b0, 32'd0);
        push_at(1'b1, 32'd21);
        push_at(1'b0, 32'd41);
        push_at(1'b0, 32'd42);
        push_at(1'b0, 32'd342);
        push_at(1'b0, 32'd343);
        push_at(1'b1, 32'd400);
        push_at(1'b0, 32'd500);
        push_at(1'b1, 32'd600);
        push_at(1'b0, 32'd700);
        push_at(1'b1, 32'd800);
        push_at(1'b0, 32'd900);
        push_at(1'b0, 32'd1201);
        push_at(1'b1, 32'd2000);
        push_at(1'b1, 32'd2500);
        push_at(1'b0, 32'd3000);
        push_at(1'b1, 32'd3100);
        push_at(1'b0, 32'd3200);
        push_at(1'b1, 32'd3300);
        push_at(1'b0, 32'd5000);
        push_at(1'b1, 32'hFFFF_FFF0);
        push_at(1'b0, 32'h0000_0010);
        push_at(1'b1, 32'h0000_0005);
        push_at(1'b0, 32'h0000_0000);
        settle();

        // No debounce, longest long press, zero click gap: the report waits for
        // the first sample whose time differs from the release.
        program_timing(0, 16'hFFFF, 0);
        push_at(1'b1, 32'd100);
        push_at(1'b0, 32'd101);
        push_at(1'b0, 32'd101);
        push_at(1'b0, 32'd102);
        random_phase(120);
        settle();

        // Longest debounce and gap, every accepted release is a long press.
        program_timing(16'hFFFF, 0, 16'hFFFF);
        t_now = $urandom();
        random_phase(120);
        settle();

        // Tight timing so events come thick; first a stretch with no idling.
        program_timing(5, 50, 30);
        quiet = 1'b1;
        random_phase(100);
        settle();
        quiet = 1'b0;
        random_phase(150);
        settle();

        // Random timing; also poke the unused index, which must change nothing.
        program_timing($urandom_range(0, 50), $urandom_range(0, 400), $urandom_range(0, 200));
        write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 16'hFFFF)));
        end_writes();
        random_phase(200);
        settle();

        program_timing(DEBOUNCE_RESET, LONG_PRESS_RESET, CLICK_GAP_RESET);
        random_phase(230);
        settle();

        repeat (8) @(posedge clk);
        bad_results += expected_events.size();
        if (bad_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
